[rtl/core/pbm_pkg.sv]
// Package for the pixel blend mode unit: operation codes, register map,
// widths and the per-channel combine function. No dependencies.
`default_nettype none

package pbm_pkg;

	localparam int CHAN_W  = 8;
	localparam int ALPHA_W = 9;
	localparam int OP_W    = 4;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

	localparam logic [OP_W-1:0] OP_BLEND      = 4'd0;
	localparam logic [OP_W-1:0] OP_DARKEN     = 4'd1;
	localparam logic [OP_W-1:0] OP_DIFFERENCE = 4'd2;
	localparam logic [OP_W-1:0] OP_LIGHTEN    = 4'd3;
	localparam logic [OP_W-1:0] OP_MULTIPLY   = 4'd4;
	localparam logic [OP_W-1:0] OP_SCREEN     = 4'd5;
	localparam logic [OP_W-1:0] OP_TINT       = 4'd6;
	localparam logic [OP_W-1:0] OP_FILL       = 4'd7;
	localparam logic [OP_W-1:0] OP_STIPPLE    = 4'd8;

	localparam logic [1:0] REG_ALPHA      = 2'd0;
	localparam logic [1:0] REG_FILL_RED   = 2'd1;
	localparam logic [1:0] REG_FILL_GREEN = 2'd2;
	localparam logic [1:0] REG_FILL_BLUE  = 2'd3;

	typedef logic [CHAN_W-1:0] chan_t;

	// One channel; a single signed 9x10 product serves blend, tint,
	// multiply and screen.
	function automatic chan_t combine_channel(
		input logic [OP_W-1:0]    op,
		input chan_t              s,
		input chan_t              d,
		input chan_t              c,
		input logic [ALPHA_W-1:0] w,
		input logic               odd
	);
		chan_t              x;
		logic signed [8:0]  ma;
		logic signed [9:0]  mb;
		logic signed [18:0] prod;
		chan_t              r;
		x = (op == OP_TINT) ? c : s;
		case (op)
			OP_BLEND, OP_TINT: begin
				ma = $signed({1'b0, x}) - $signed({1'b0, d});
				mb = $signed({1'b0, w});
			end
			OP_MULTIPLY: begin
				ma = $signed({1'b0, s});
				mb = $signed({2'b00, d});
			end
			OP_SCREEN: begin
				ma = $signed({1'b0, ~s});
				mb = $signed({2'b00, ~d});
			end
			default: begin
				ma = 9'sd0;
				mb = 10'sd0;
			end
		endcase
		prod = ma * mb;
		case (op)
			OP_BLEND, OP_TINT: r = d + prod[15:8];
			OP_DARKEN:         r = (s < d) ? s : d;
			OP_DIFFERENCE:     r = (s > d) ? (s - d) : (d - s);
			OP_LIGHTEN:        r = (s > d) ? s : d;
			OP_MULTIPLY:       r = prod[15:8];
			OP_SCREEN:         r = ~prod[15:8];
			OP_FILL:           r = c;
			OP_STIPPLE:        r = odd ? d : c;
			default:           r = d;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/pixel_blend_mode_unit_top.sv]
// Pixel blend mode unit: input register, combine logic, result register,
// APB register block. Depends on pbm_pkg.
//
// channel   dir  handshake              payload
// s_axis    in   tvalid/tready          source/destination pixel, op, parity
// m_axis    out  tvalid/tready          result pixel
// apb       in   psel/penable/pready    alpha and fill colour registers
//
// One pixel per clock sustained while m_axis_tready is high.
// The input register and result register each hold one request; the path
// between them is one 9x10 multiply and an add per channel.
// Reset clears both valid flags; alpha resets to 256, fill colour to 0.
// A stalled result stops the input stage only when the input register is full.
`default_nettype none

module pixel_blend_mode_unit_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output      logic                        s_axis_tready,
	// src_blue, src_green, src_red, dst_blue, dst_green, dst_red
	input  wire logic [47:0]                 s_axis_tdata,
	// operation [3:0], checker_odd [4]
	input  wire logic [4:0]                  s_axis_tuser,
	output      logic                        m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// out_blue, out_green, out_red
	output      logic [23:0]                 m_axis_tdata,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pbm_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pbm_pkg::DATA_W-1:0]  pwdata,
	output      logic [pbm_pkg::DATA_W-1:0]  prdata,
	output      logic                        pready
);

	logic [pbm_pkg::ALPHA_W-1:0] alpha_q;
	pbm_pkg::chan_t              fill_red_q;
	pbm_pkg::chan_t              fill_green_q;
	pbm_pkg::chan_t              fill_blue_q;
	logic                        wr_en;
	logic [1:0]                  reg_idx;
	logic [pbm_pkg::ALPHA_W-1:0] weight;

	logic                        valid_s1;
	logic [pbm_pkg::OP_W-1:0]    op_s1;
	logic                        odd_s1;
	logic [47:0]                 pix_s1;
	logic                        valid_s2;
	logic [23:0]                 res_s2;

	logic                        out_free;
	logic                        adv;
	logic                        in_acc;
	logic [23:0]                 res;

	// register block
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q      <= pbm_pkg::ALPHA_ONE;
			fill_red_q   <= '0;
			fill_green_q <= '0;
			fill_blue_q  <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				pbm_pkg::REG_ALPHA:      alpha_q      <= pwdata[pbm_pkg::ALPHA_W-1:0];
				pbm_pkg::REG_FILL_RED:   fill_red_q   <= pwdata[pbm_pkg::CHAN_W-1:0];
				pbm_pkg::REG_FILL_GREEN: fill_green_q <= pwdata[pbm_pkg::CHAN_W-1:0];
				pbm_pkg::REG_FILL_BLUE:  fill_blue_q  <= pwdata[pbm_pkg::CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			pbm_pkg::REG_ALPHA:      prdata = {23'd0, alpha_q};
			pbm_pkg::REG_FILL_RED:   prdata = {24'd0, fill_red_q};
			pbm_pkg::REG_FILL_GREEN: prdata = {24'd0, fill_green_q};
			pbm_pkg::REG_FILL_BLUE:  prdata = {24'd0, fill_blue_q};
			default:                 prdata = '0;
		endcase
	end

	// weight saturates at 256
	assign weight = (alpha_q > pbm_pkg::ALPHA_ONE) ? pbm_pkg::ALPHA_ONE : alpha_q;

	// handshake
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv           = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (out_free)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1 <= s_axis_tdata;
			op_s1  <= s_axis_tuser[3:0];
			odd_s1 <= s_axis_tuser[4];
		end
		if (adv)
			res_s2 <= res;
	end

	assign res[7:0]   = pbm_pkg::combine_channel(op_s1, pix_s1[7:0], pix_s1[31:24],
		fill_blue_q, weight, odd_s1);
	assign res[15:8]  = pbm_pkg::combine_channel(op_s1, pix_s1[15:8], pix_s1[39:32],
		fill_green_q, weight, odd_s1);
	assign res[23:16] = pbm_pkg::combine_channel(op_s1, pix_s1[23:16], pix_s1[47:40],
		fill_red_q, weight, odd_s1);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = res_s2;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !m_axis_tready) |-> !s_axis_tready)
		else $error("request taken while both stages are blocked");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> valid_s1)
		else $error("accepted request not held in input register");

	a_alpha_write: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && reg_idx == pbm_pkg::REG_ALPHA) |=>
		alpha_q == $past(pwdata[pbm_pkg::ALPHA_W-1:0]))
		else $error("alpha register write lost");

endmodule

`default_nettype wire
